@@ sv/phc_pkg.sv @@
package phc_pkg;

  // histogram geometry
  localparam int NUM_BINS   = 256;
  localparam int COUNT_BITS = 32;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int OUT_BITS   = 32;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // command codes
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // classified operation codes
  localparam logic [1:0] OP_COUNT    = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_READ_OOR = 2'd2;
  localparam logic [1:0] OP_DROP     = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_value;
    logic [7:0] bin_index;
  } in_t;

  typedef struct packed {
    logic [7:0]          read_bin;
    logic [OUT_BITS-1:0] bin_count;
  } out_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [BIN_W-1:0] addr;
    logic [7:0]       tag;
  } phc_op_t;

  typedef struct packed {
    logic    valid;
    phc_op_t op;
  } q_head_t;

  // saturating increment of one counter
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
  endfunction

  // clamp a counter to the result width
  function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'hFFFF_FFFF) ? {OUT_BITS{1'b1}} : w[OUT_BITS-1:0];
  endfunction

endpackage

@@ sv/phc_ram.sv @@
module phc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/phc_front.sv @@
module phc_front (
  input  logic           pix_valid,
  output logic           pix_stall,
  input  phc_pkg::in_t   pix_data,
  input  logic           q_full,
  output logic           q_push,
  output phc_pkg::phc_op_t q_op
);
  import phc_pkg::*;

  logic in_range;

  // classify the beat into a back-end operation
  always_comb begin
    q_op = '0;
    if (pix_data.cmd == CMD_COUNT) begin
      in_range   = 32'(pix_data.pixel_value) < NUM_BINS;
      q_op.kind  = in_range ? OP_COUNT : OP_DROP;
      q_op.addr  = BIN_W'(pix_data.pixel_value);
      q_op.tag   = pix_data.pixel_value;
    end else begin
      in_range   = 32'(pix_data.bin_index) < NUM_BINS;
      q_op.kind  = in_range ? OP_READ : OP_READ_OOR;
      q_op.addr  = BIN_W'(pix_data.bin_index);
      q_op.tag   = pix_data.bin_index;
    end
  end

  // accept while the queue has room, counts outside the bins are dropped here
  assign pix_stall = q_full;
  assign q_push    = pix_valid && !q_full && (q_op.kind != OP_DROP);

endmodule

@@ sv/phc_queue.sv @@
module phc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  phc_pkg::phc_op_t  push_op,
  output logic              full,
  input  logic              pop,
  output phc_pkg::q_head_t  head
);
  import phc_pkg::*;

  phc_op_t            entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_PTR_W:0]   cnt;

  assign full       = cnt == (Q_PTR_W+1)'(Q_DEPTH);
  assign head.valid = cnt != '0;
  assign head.op    = entries[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (Q_PTR_W+1)'(1);
      end
    end
  end

endmodule

@@ sv/phc_back.sv @@
module phc_back (
  input  logic             clk,
  input  logic             rst,
  input  phc_pkg::q_head_t head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output phc_pkg::out_t    res_data
);
  import phc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state;
  logic                  state_next;
  phc_op_t               op;
  logic                  op_filled;
  logic [NUM_BINS-1:0]   filled;
  logic                  ram_we;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cur;
  logic                  out_free;
  logic                  res_load;
  logic [OUT_BITS-1:0]   res_count;

  phc_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NUM_BINS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(op.addr),
    .wdata(ram_wdata),
    .re   (pop),
    .raddr(head.op.addr),
    .rdata(ram_rdata)
  );

  // a bin never written since reset reads as zero
  assign cur       = op_filled ? ram_rdata : '0;
  assign ram_wdata = sat_inc(cur);
  assign out_free  = !res_valid || !res_stall;

  // sequencer: read the counter, then update it or report it
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ram_we     = 1'b0;
    res_load   = 1'b0;
    res_count  = sat_out(cur);
    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op.kind) inside
          OP_COUNT: begin
            ram_we     = 1'b1;
            state_next = ST_IDLE;
          end
          OP_READ, OP_READ_OOR: begin
            if (op.kind == OP_READ_OOR) begin
              res_count = '0;
            end
            if (out_free) begin
              res_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state and bin fill flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      filled    <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        filled[op.addr] <= 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // operation latch and result register
  always_ff @(posedge clk) begin
    if (pop) begin
      op        <= head.op;
      op_filled <= filled[head.op.addr];
    end
    if (res_load) begin
      res_data.read_bin  <= op.tag;
      res_data.bin_count <= res_count;
    end
  end

endmodule

@@ sv/pixel_histogram_counter_core.sv @@
// channel  direction  beat type        handshake
// pix      in         phc_pkg::in_t    pix_valid / pix_stall
// res      out        phc_pkg::out_t   res_valid / res_stall
//
// the back end takes each queued command through IDLE (pop it, registered read of
// the counter memory) and EXEC (write the incremented count or load the result)
// the front takes a beat every cycle while the 4-entry queue has room
// reset is synchronous; it empties the queue, the result register and the
// per-bin fill flags, so every bin reads zero straight after reset
// a stalled result holds the back end only when a read is waiting to report
module pixel_histogram_counter_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  output logic          pix_stall,
  input  phc_pkg::in_t  pix_data,
  output logic          res_valid,
  input  logic          res_stall,
  output phc_pkg::out_t res_data
);
  import phc_pkg::*;

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  phc_op_t q_op;
  q_head_t q_head;

  // classify and accept
  phc_front u_front (
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix_data (pix_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_op)
  );

  // decoupling queue
  phc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .push_op(q_op),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head)
  );

  // counter memory and result
  phc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .pop      (q_pop),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
  );

endmodule

@@ sv/phc_checker.sv @@
module phc_checker (
  input logic          clk,
  input logic          rst,
  input logic          pix_valid,
  input logic          pix_stall,
  input phc_pkg::in_t  pix_data,
  input logic          res_valid,
  input logic          res_stall,
  input phc_pkg::out_t res_data
);

  // no result survives reset
  a_rst_res: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // queue is empty after reset, so input is open
  a_rst_open: assert property (@(posedge clk) rst |=> !pix_stall)
    else $error("input stalled right after reset");

  // stalled input beat stays offered with the same payload
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pix_data))
    else $error("input beat changed under stall");

  // stalled result beat stays
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result beat dropped under stall");

  // stalled result beat keeps its payload
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res_data))
    else $error("result payload changed under stall");

endmodule

bind pixel_histogram_counter_core phc_checker u_chk (.*);
